>>> rtl/core/twr_pkg.sv
// Package with shared types and constants of the write receiver.
package twr_pkg;

   // Register file geometry of the configuration port.
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 64;

   // Protocol constants.
   localparam logic [15:0] DEFAULT_BLOCK = 16'd512;
   localparam logic [15:0] BLKSIZE_MIN   = 16'd8;
   localparam logic [15:0] BLKSIZE_MAX   = 16'd65464;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BLOCK_SIZE_LIMIT     = 3'd0,
      CSR_TIMEOUT_LIMIT        = 3'd1,
      CSR_TRANSFER_SIZE_ENABLE = 3'd2,
      CSR_STORAGE_CAPACITY     = 3'd3,
      CSR_DALLY_ENABLE         = 3'd4
   } csr_index_type;

   // Event kinds carried by a request.
   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_DATA  = 2'd1,
      MODE_ACK   = 2'd2
   } mode_type;

   // Packet kinds to send.
   typedef enum logic [1:0] {
      SEND_NONE  = 2'd0,
      SEND_ACK   = 2'd1,
      SEND_OACK  = 2'd2,
      SEND_ERROR = 2'd3
   } send_kind_type;

   // Error reasons.
   typedef enum logic [2:0] {
      ERR_NONE           = 3'd0,
      ERR_FILE_TOO_BIG   = 3'd1,
      ERR_WRONG_BLOCK    = 3'd2,
      ERR_TOO_MUCH_DATA  = 3'd3,
      ERR_ACK_UNEXPECTED = 3'd4
   } error_reason_type;

   // Transfer phases, also reported as status.
   typedef enum logic [2:0] {
      PHASE_IDLE      = 3'd0,
      PHASE_RECEIVING = 3'd1,
      PHASE_DALLYING  = 3'd2,
      PHASE_FINISHED  = 3'd3,
      PHASE_ERROR     = 3'd4
   } phase_type;

   // Payload of one request.
   typedef struct packed {
      logic [1:0]  mode;
      logic        client_options_present;
      logic        extra_options_present;
      logic        req_blksize_present;
      logic [15:0] req_blksize;
      logic        req_timeout_present;
      logic [7:0]  req_timeout;
      logic        req_tsize_present;
      logic [63:0] req_tsize;
      logic [15:0] block_number;
      logic [15:0] data_size;
   } req_payload_type;

   // Payload of one response.
   typedef struct packed {
      logic [1:0]  send_kind;
      logic [15:0] ack_block;
      logic        oack_blksize_present;
      logic [15:0] oack_blksize;
      logic        oack_timeout_present;
      logic [7:0]  oack_timeout;
      logic        oack_tsize_present;
      logic [63:0] oack_tsize;
      logic [2:0]  error_reason;
      logic        deliver_data;
      logic [2:0]  status;
   } rsp_payload_type;

endpackage

>>> rtl/core/twr_channels.sv
// Valid/ready channel interfaces for requests and responses.
interface twr_req_if;
   logic                     valid;
   logic                     ready;
   twr_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface twr_rsp_if;
   logic                     valid;
   logic                     ready;
   twr_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/tftp_write_receiver_unit.sv
// Receiving side of a file write: option negotiation and data block checks.
// Throughput: one request per cycle; an input register and a response register
// separate the two sides, so a waiting response stops intake only once the
// input register is also full.
// Reset (synchronous, active high): configuration returns to its defaults,
// the transfer goes idle with block 0 and a block size of 512; both stages empty.
module tftp_write_receiver_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   twr_req_if.sink                                req_chan,
   twr_rsp_if.source                              rsp_chan,
   input  logic                                   csr_write_enable,
   input  logic [twr_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [twr_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);

   // Configuration registers.
   logic [15:0] blk_limit_ff;
   logic [7:0]  tmo_limit_ff;
   logic        tsize_en_ff;
   logic [63:0] capacity_ff;
   logic        dally_en_ff;

   // Transfer state.
   logic [15:0]        last_block_ff, last_block_in;
   logic [15:0]        blk_in_use_ff, blk_in_use_in;
   twr_pkg::phase_type phase_ff, phase_in;

   // Pipeline registers.
   logic                     in_valid_ff;
   twr_pkg::req_payload_type in_ff;
   logic                     out_valid_ff;
   twr_pkg::rsp_payload_type out_ff, out_in;

   logic        advance;
   logic        active;
   logic [15:0] next_block;
   logic        blk_grant;
   logic [15:0] granted_blk;
   logic        tmo_grant;
   logic        tsize_req;
   logic        tsize_bad;
   logic        block_short;
   twr_pkg::phase_type end_phase;

   // Handshake: the work stage moves when the response register is free.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   // Option checks of a start request.
   assign blk_grant = in_ff.client_options_present && (blk_limit_ff != 16'd0)
                      && in_ff.req_blksize_present
                      && (in_ff.req_blksize >= twr_pkg::BLKSIZE_MIN)
                      && (in_ff.req_blksize <= twr_pkg::BLKSIZE_MAX);
   assign granted_blk = (in_ff.req_blksize < blk_limit_ff) ? in_ff.req_blksize
                                                           : blk_limit_ff;
   assign tmo_grant = in_ff.client_options_present && (tmo_limit_ff != 8'd0)
                      && in_ff.req_timeout_present && (in_ff.req_timeout != 8'd0)
                      && (in_ff.req_timeout <= tmo_limit_ff);
   assign tsize_req = in_ff.client_options_present && tsize_en_ff
                      && in_ff.req_tsize_present;
   assign tsize_bad = tsize_req && (in_ff.req_tsize > capacity_ff);

   // Data block checks.
   assign active      = (phase_ff == twr_pkg::PHASE_RECEIVING)
                        || (phase_ff == twr_pkg::PHASE_DALLYING);
   assign next_block  = last_block_ff + 16'd1;
   assign block_short = in_ff.data_size < blk_in_use_ff;
   assign end_phase   = block_short ? (dally_en_ff ? twr_pkg::PHASE_DALLYING
                                                   : twr_pkg::PHASE_FINISHED)
                                    : twr_pkg::PHASE_RECEIVING;

   // Event handling: response and next transfer state.
   always_comb begin
      out_in        = '0;
      last_block_in = last_block_ff;
      blk_in_use_in = blk_in_use_ff;
      phase_in      = phase_ff;
      case (twr_pkg::mode_type'(in_ff.mode))
         twr_pkg::MODE_START: begin
            last_block_in = 16'd0;
            blk_in_use_in = twr_pkg::DEFAULT_BLOCK;
            if (!in_ff.client_options_present && !in_ff.extra_options_present) begin
               out_in.send_kind = twr_pkg::SEND_ACK;
               phase_in         = twr_pkg::PHASE_RECEIVING;
            end else begin
               if (blk_grant) begin
                  blk_in_use_in = granted_blk;
               end
               if (tsize_bad) begin
                  out_in.send_kind    = twr_pkg::SEND_ERROR;
                  out_in.error_reason = twr_pkg::ERR_FILE_TOO_BIG;
                  phase_in            = twr_pkg::PHASE_ERROR;
               end else begin
                  out_in.oack_blksize_present = blk_grant;
                  out_in.oack_blksize         = blk_grant ? granted_blk : 16'd0;
                  out_in.oack_timeout_present = tmo_grant;
                  out_in.oack_timeout         = tmo_grant ? in_ff.req_timeout : 8'd0;
                  out_in.oack_tsize_present   = tsize_req;
                  out_in.oack_tsize           = tsize_req ? in_ff.req_tsize : 64'd0;
                  out_in.send_kind = (blk_grant || tmo_grant || tsize_req
                                      || in_ff.extra_options_present)
                                     ? twr_pkg::SEND_OACK : twr_pkg::SEND_ACK;
                  phase_in = twr_pkg::PHASE_RECEIVING;
               end
            end
         end
         twr_pkg::MODE_DATA: begin
            if (active) begin
               if (in_ff.block_number == last_block_ff) begin
                  out_in.send_kind = twr_pkg::SEND_ACK;
                  out_in.ack_block = last_block_ff;
                  phase_in         = end_phase;
               end else if (in_ff.block_number != next_block) begin
                  out_in.send_kind    = twr_pkg::SEND_ERROR;
                  out_in.error_reason = twr_pkg::ERR_WRONG_BLOCK;
                  phase_in            = twr_pkg::PHASE_ERROR;
               end else if (in_ff.data_size > blk_in_use_ff) begin
                  out_in.send_kind    = twr_pkg::SEND_ERROR;
                  out_in.error_reason = twr_pkg::ERR_TOO_MUCH_DATA;
                  phase_in            = twr_pkg::PHASE_ERROR;
               end else begin
                  out_in.deliver_data = 1'b1;
                  out_in.send_kind    = twr_pkg::SEND_ACK;
                  out_in.ack_block    = next_block;
                  last_block_in       = next_block;
                  phase_in            = end_phase;
               end
            end
         end
         twr_pkg::MODE_ACK: begin
            if (active) begin
               out_in.send_kind    = twr_pkg::SEND_ERROR;
               out_in.error_reason = twr_pkg::ERR_ACK_UNEXPECTED;
               phase_in            = twr_pkg::PHASE_ERROR;
            end
         end
         default: begin
         end
      endcase
      out_in.status = phase_in;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         blk_limit_ff <= twr_pkg::DEFAULT_BLOCK;
         tmo_limit_ff <= 8'd0;
         tsize_en_ff  <= 1'b0;
         capacity_ff  <= '1;
         dally_en_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         case (twr_pkg::csr_index_type'(csr_index))
            twr_pkg::CSR_BLOCK_SIZE_LIMIT:     blk_limit_ff <= csr_write_data[15:0];
            twr_pkg::CSR_TIMEOUT_LIMIT:        tmo_limit_ff <= csr_write_data[7:0];
            twr_pkg::CSR_TRANSFER_SIZE_ENABLE: tsize_en_ff  <= csr_write_data[0];
            twr_pkg::CSR_STORAGE_CAPACITY:     capacity_ff  <= csr_write_data[63:0];
            twr_pkg::CSR_DALLY_ENABLE:         dally_en_ff  <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // Transfer state and pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_block_ff <= 16'd0;
         blk_in_use_ff <= twr_pkg::DEFAULT_BLOCK;
         phase_ff      <= twr_pkg::PHASE_IDLE;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            last_block_ff <= last_block_in;
            blk_in_use_ff <= blk_in_use_in;
            phase_ff      <= phase_in;
         end
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_ff <= req_chan.payload;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

`ifndef SYNTH
   // An error response always names a reason, and only an error response does.
   a_error_reason: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_ff.send_kind == twr_pkg::SEND_ERROR)
                        == (out_ff.error_reason != twr_pkg::ERR_NONE)))
      else $error("error reason does not match send kind");

   // Delivered data is always acknowledged and leaves the transfer alive or done.
   a_deliver_ack: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.deliver_data)
      |-> (out_ff.send_kind == twr_pkg::SEND_ACK)
          && (out_ff.status != twr_pkg::PHASE_ERROR)
          && (out_ff.status != twr_pkg::PHASE_IDLE))
      else $error("delivered data without a matching ACK");

   // Option fields appear only in an option ACK.
   a_oack_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.send_kind != twr_pkg::SEND_OACK))
      |-> !out_ff.oack_blksize_present && !out_ff.oack_timeout_present
          && !out_ff.oack_tsize_present)
      else $error("option fields outside an option ACK");

   // The transfer state changes only when a request is processed.
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(last_block_ff))
      else $error("transfer state changed without a request");
`endif

endmodule

>>> sim/tb.sv
// Self-checking testbench of the write receiver with a predicting scoreboard.
`timescale 1ns / 100ps

module tb;
   import twr_pkg::*;

   localparam int          CLOCK_PERIOD = 10;
   localparam int          RESET_CYCLES = 9;
   localparam int          LATENCY      = 2;
   localparam int          MAX_IDLE     = 12;
   localparam int          QUIET_LIMIT  = 4000;
   localparam logic [1:0]  MODE_UNUSED  = 2'd3;
   localparam logic [63:0] ALL_ONES     = {64{1'b1}};

   // Predicts each response of the block and checks the responses in order.
   class transfer_scoreboard;
      logic [15:0]     cfg_blk_limit;
      logic [7:0]      cfg_timeout_limit;
      logic            cfg_tsize_enable;
      logic [63:0]     cfg_capacity;
      logic            cfg_dally;
      logic [15:0]     last_block;
      logic [15:0]     blk_in_use;
      phase_type       phase;
      rsp_payload_type expected_q[$];
      int              mismatches;
      int              checked;
      int              kind_count[4];

      function new();
         cfg_blk_limit     = DEFAULT_BLOCK;
         cfg_timeout_limit = 8'd0;
         cfg_tsize_enable  = 1'b0;
         cfg_capacity      = ALL_ONES;
         cfg_dally         = 1'b0;
         last_block        = 16'd0;
         blk_in_use        = DEFAULT_BLOCK;
         phase             = PHASE_IDLE;
         mismatches        = 0;
         checked           = 0;
         kind_count        = '{0, 0, 0, 0};
      endfunction

      function void set_config(logic [15:0] blk, logic [7:0] tmo, logic tse,
                               logic [63:0] cap, logic dal);
         cfg_blk_limit     = blk;
         cfg_timeout_limit = tmo;
         cfg_tsize_enable  = tse;
         cfg_capacity      = cap;
         cfg_dally         = dal;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Works out the response of one accepted request and advances the transfer.
      function void note_request(req_payload_type r);
         rsp_payload_type o;
         logic [15:0]     next_block;
         logic            cli;
         logic            granted;
         logic            refused;
         logic            acked;
         o          = '0;
         cli        = r.client_options_present;
         granted    = 1'b0;
         refused    = 1'b0;
         acked      = 1'b0;
         next_block = last_block + 16'd1;
         if (r.mode == MODE_START) begin
            // A start restarts the transfer from block 0 at the default size.
            last_block = 16'd0;
            blk_in_use = DEFAULT_BLOCK;
            if (!cli && !r.extra_options_present) begin
               o.send_kind = SEND_ACK;
            end else begin
               // Block size: a request in range is clamped to the limit.
               if (cli && cfg_blk_limit != 16'd0 && r.req_blksize_present &&
                   r.req_blksize >= BLKSIZE_MIN && r.req_blksize <= BLKSIZE_MAX) begin
                  blk_in_use = (r.req_blksize < cfg_blk_limit) ? r.req_blksize
                                                               : cfg_blk_limit;
                  o.oack_blksize_present = 1'b1;
                  o.oack_blksize         = blk_in_use;
                  granted                = 1'b1;
               end
               // Timeout: accepted only from 1 up to the limit.
               if (cli && cfg_timeout_limit != 8'd0 && r.req_timeout_present &&
                   r.req_timeout != 8'd0 && r.req_timeout <= cfg_timeout_limit) begin
                  o.oack_timeout_present = 1'b1;
                  o.oack_timeout         = r.req_timeout;
                  granted                = 1'b1;
               end
               // Transfer size: echoed, or refused when the sink cannot hold it.
               if (cli && cfg_tsize_enable && r.req_tsize_present) begin
                  if (r.req_tsize > cfg_capacity) begin
                     o              = '0;
                     o.send_kind    = SEND_ERROR;
                     o.error_reason = ERR_FILE_TOO_BIG;
                     refused        = 1'b1;
                  end else begin
                     o.oack_tsize_present = 1'b1;
                     o.oack_tsize         = r.req_tsize;
                     granted              = 1'b1;
                  end
               end
               if (!refused) begin
                  o.send_kind = (granted || r.extra_options_present) ? SEND_OACK : SEND_ACK;
               end
            end
            phase = refused ? PHASE_ERROR : PHASE_RECEIVING;
         end else if (phase == PHASE_RECEIVING || phase == PHASE_DALLYING) begin
            if (r.mode == MODE_DATA) begin
               if (r.block_number == last_block) begin
                  acked = 1'b1;
               end else if (r.block_number != next_block) begin
                  o.send_kind    = SEND_ERROR;
                  o.error_reason = ERR_WRONG_BLOCK;
                  phase          = PHASE_ERROR;
               end else if (r.data_size > blk_in_use) begin
                  o.send_kind    = SEND_ERROR;
                  o.error_reason = ERR_TOO_MUCH_DATA;
                  phase          = PHASE_ERROR;
               end else begin
                  o.deliver_data = 1'b1;
                  last_block     = next_block;
                  acked          = 1'b1;
               end
               // A short block ends the transfer, a full one keeps it going.
               if (acked) begin
                  o.send_kind = SEND_ACK;
                  o.ack_block = last_block;
                  if (r.data_size < blk_in_use) begin
                     phase = cfg_dally ? PHASE_DALLYING : PHASE_FINISHED;
                  end else begin
                     phase = PHASE_RECEIVING;
                  end
               end
            end else if (r.mode == MODE_ACK) begin
               o.send_kind    = SEND_ERROR;
               o.error_reason = ERR_ACK_UNEXPECTED;
               phase          = PHASE_ERROR;
            end
         end
         o.status = phase;
         expected_q.push_back(o);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) begin
            $display("MISMATCH at response %0d: %s", checked, msg);
         end
      endtask

      task check_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want) begin
            report($sformatf("%s is %0h, expected %0h", name, got, want));
         end
      endtask

      // Compares one accepted response with the oldest prediction.
      task check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            report("response arrived with no request waiting");
            return;
         end
         want = expected_q.pop_front();
         checked++;
         kind_count[want.send_kind]++;
         check_field("send_kind", 64'(got.send_kind), 64'(want.send_kind));
         check_field("ack_block", 64'(got.ack_block), 64'(want.ack_block));
         check_field("oack_blksize_present", 64'(got.oack_blksize_present),
                     64'(want.oack_blksize_present));
         check_field("oack_blksize", 64'(got.oack_blksize), 64'(want.oack_blksize));
         check_field("oack_timeout_present", 64'(got.oack_timeout_present),
                     64'(want.oack_timeout_present));
         check_field("oack_timeout", 64'(got.oack_timeout), 64'(want.oack_timeout));
         check_field("oack_tsize_present", 64'(got.oack_tsize_present),
                     64'(want.oack_tsize_present));
         check_field("oack_tsize", got.oack_tsize, want.oack_tsize);
         check_field("error_reason", 64'(got.error_reason), 64'(want.error_reason));
         check_field("deliver_data", 64'(got.deliver_data), 64'(want.deliver_data));
         check_field("status", 64'(got.status), 64'(want.status));
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;
   logic                       idle_on = 1'b1;
   int                         sent = 0;
   int                         directed = 0;
   int                         settings = 0;
   transfer_scoreboard         sb = new();

   twr_req_if req_chan();
   twr_rsp_if rsp_chan();

   tftp_write_receiver_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic req_payload_type mk_start(logic cli, logic extra,
                                                logic bp, logic [15:0] b,
                                                logic tp, logic [7:0] t,
                                                logic sp, logic [63:0] s);
      req_payload_type r;
      r                        = '0;
      r.mode                   = MODE_START;
      r.client_options_present = cli;
      r.extra_options_present  = extra;
      r.req_blksize_present    = bp;
      r.req_blksize            = b;
      r.req_timeout_present    = tp;
      r.req_timeout            = t;
      r.req_tsize_present      = sp;
      r.req_tsize              = s;
      return r;
   endfunction

   function automatic req_payload_type mk_data(logic [15:0] bn, logic [15:0] size);
      req_payload_type r;
      r              = '0;
      r.mode         = MODE_DATA;
      r.block_number = bn;
      r.data_size    = size;
      return r;
   endfunction

   function automatic req_payload_type mk_event(logic [1:0] mode);
      req_payload_type r;
      r      = '0;
      r.mode = mode;
      return r;
   endfunction

   // Start request with options aimed at the limits now in force.
   function automatic req_payload_type random_start();
      logic [15:0] b;
      logic [7:0]  t;
      logic [63:0] s;
      case ($urandom_range(0, 5))
         0: b = 16'($urandom);
         1: b = 16'($urandom_range(BLKSIZE_MIN, BLKSIZE_MAX));
         2: b = sb.cfg_blk_limit + 16'($urandom_range(0, 2)) - 16'd1;
         3: begin
            case ($urandom_range(0, 5))
               0: b = 16'd0;
               1: b = BLKSIZE_MIN - 16'd1;
               2: b = BLKSIZE_MIN;
               3: b = BLKSIZE_MAX;
               4: b = BLKSIZE_MAX + 16'd1;
               default: b = 16'hFFFF;
            endcase
         end
         default: b = 16'($urandom_range(8, 1500));
      endcase
      case ($urandom_range(0, 3))
         0: t = 8'($urandom);
         1: t = sb.cfg_timeout_limit + 8'($urandom_range(0, 2)) - 8'd1;
         2: t = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'hFF;
         default: t = 8'($urandom_range(1, 60));
      endcase
      case ($urandom_range(0, 4))
         0: s = {$urandom, $urandom};
         1: s = 64'($urandom_range(0, 100000));
         2: s = sb.cfg_capacity;
         3: s = sb.cfg_capacity + 64'd1;
         default: s = ($urandom_range(0, 1) == 0) ? 64'd0 : ALL_ONES;
      endcase
      return mk_start(1'($urandom_range(0, 99) < 85), 1'($urandom_range(0, 99) < 30),
                      1'($urandom_range(0, 3) != 0), b, 1'($urandom_range(0, 3) != 0), t,
                      1'($urandom_range(0, 3) != 0), s);
   endfunction

   // Offers one request after a random gap and waits for it to be taken.
   task automatic send_request(input req_payload_type r);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(r);
      sent++;
   endtask

   // Stops offering requests until every predicted response has come back.
   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // Writes all registers while the block is idle.
   task automatic reconfigure(logic [15:0] blk, logic [7:0] tmo, logic tse,
                              logic [63:0] cap, logic dal);
      hold_until_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BLOCK_SIZE_LIMIT;
      csr_write_data   <= 64'(blk);
      @(posedge clock);
      csr_index        <= CSR_TIMEOUT_LIMIT;
      csr_write_data   <= 64'(tmo);
      @(posedge clock);
      csr_index        <= CSR_TRANSFER_SIZE_ENABLE;
      csr_write_data   <= 64'(tse);
      @(posedge clock);
      csr_index        <= CSR_STORAGE_CAPACITY;
      csr_write_data   <= cap;
      @(posedge clock);
      csr_index        <= CSR_DALLY_ENABLE;
      csr_write_data   <= 64'(dal);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_config(blk, tmo, tse, cap, dal);
      settings++;
   endtask

   // Random transfers: mostly in-order blocks, with repeats, faults and restarts.
   task automatic run_transfers(input int count);
      req_payload_type r;
      logic [15:0]     full;
      int              k;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 39) == 0) idle_on = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 119) == 0) hold_until_drained();
         full = sb.blk_in_use;
         k    = $urandom_range(0, 99);
         if (sb.phase != PHASE_RECEIVING && sb.phase != PHASE_DALLYING) begin
            if (k < 85) begin
               r = random_start();
            end else if (k < 93) begin
               r = mk_data(16'($urandom), 16'($urandom));
            end else begin
               r = mk_event(($urandom_range(0, 1) == 0) ? MODE_ACK : MODE_UNUSED);
            end
         end else if (k < 66) begin
            r = mk_data(sb.last_block + 16'd1, ($urandom_range(0, 9) == 0)
                        ? 16'($urandom_range(0, full - 16'd1)) : full);
         end else if (k < 76) begin
            r = mk_data(sb.last_block, ($urandom_range(0, 1) == 0)
                        ? 16'($urandom_range(0, full - 16'd1)) : full);
         end else if (k < 82) begin
            r = mk_data(sb.last_block + 16'($urandom_range(2, 65535)),
                        16'($urandom_range(0, full)));
         end else if (k < 88) begin
            r = mk_data(sb.last_block + 16'd1, 16'($urandom_range(full + 1, 65535)));
         end else if (k < 92) begin
            r = mk_event(MODE_ACK);
         end else if (k < 95) begin
            r = mk_event(MODE_UNUSED);
         end else begin
            r = random_start();
         end
         // Fields the event does not use still toggle.
         if (r.mode != MODE_START) begin
            r.client_options_present = 1'($urandom);
            r.extra_options_present  = 1'($urandom);
            r.req_blksize_present    = 1'($urandom);
            r.req_blksize            = 16'($urandom);
            r.req_timeout_present    = 1'($urandom);
            r.req_timeout            = 8'($urandom);
            r.req_tsize_present      = 1'($urandom);
            r.req_tsize              = {$urandom, $urandom};
         end
         if (r.mode != MODE_DATA) begin
            r.block_number = 16'($urandom);
            r.data_size    = 16'($urandom);
         end
         send_request(r);
      end
   endtask

   // Response side: random stalls, then check each accepted response.
   initial begin : response_side
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         sb.check_response(rsp_chan.payload);
      end
   end

   // Ends the run when no request or response moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("[tftp_write_receiver_unit] ERROR");
      $finish;
   end

   initial begin : stimulus
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_BLOCK_SIZE_LIMIT;
      csr_write_data   <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Before the first start every event is ignored.
      send_request(mk_data(16'd1, 16'd512));
      send_request(mk_event(MODE_ACK));
      send_request(mk_event(MODE_UNUSED));
      // Options without the client flag are ignored: plain ACK 0.
      send_request(mk_start(1'b0, 1'b0, 1'b1, 16'd1024, 1'b1, 8'd5, 1'b1, 64'd10));
      send_request(mk_data(16'd1, 16'd512));
      send_request(mk_data(16'd1, 16'd512));
      send_request(mk_data(16'd2, 16'd0));
      send_request(mk_data(16'd3, 16'd512));

      reconfigure(16'd1024, 8'd30, 1'b1, 64'd1_000_000, 1'b1);
      // Every option granted, block size clamped, transfer size at capacity.
      send_request(mk_start(1'b1, 1'b0, 1'b1, 16'd2000, 1'b1, 8'd30, 1'b1, 64'd1_000_000));
      send_request(mk_data(16'd1, 16'd1025));
      send_request(mk_event(MODE_ACK));
      // Block size below range and a zero timeout count as absent.
      send_request(mk_start(1'b1, 1'b0, 1'b1, 16'd7, 1'b1, 8'd0, 1'b0, 64'd0));
      // Only server options: an option ACK with nothing in it.
      send_request(mk_start(1'b0, 1'b1, 1'b1, 16'd100, 1'b1, 8'd3, 1'b1, 64'd5));
      send_request(mk_start(1'b1, 1'b0, 1'b1, 16'd65465, 1'b1, 8'd31, 1'b1,
                            64'd1_000_001));
      send_request(mk_start(1'b1, 1'b0, 1'b1, BLKSIZE_MIN, 1'b1, 8'd1, 1'b1, 64'd0));
      send_request(mk_data(16'd5, 16'd8));
      send_request(mk_start(1'b1, 1'b1, 1'b1, BLKSIZE_MAX, 1'b1, 8'd255, 1'b0, ALL_ONES));
      send_request(mk_data(16'd1, 16'd1024));
      send_request(mk_event(MODE_ACK));
      // Short block with dally on, then a retransmission and more data while dallying.
      send_request(mk_start(1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0, 1'b0, 64'd0));
      send_request(mk_data(16'd1, 16'd100));
      send_request(mk_data(16'd1, 16'd100));
      send_request(mk_data(16'd2, 16'd0));
      send_request(mk_event(MODE_UNUSED));
      send_request(mk_start(1'b1, 1'b0, 1'b0, 16'hFFFF, 1'b0, 8'hFF, 1'b1, ALL_ONES));
      directed = sent;

      // Random transfers under a range of register settings.
      reconfigure(DEFAULT_BLOCK, 8'd0, 1'b0, ALL_ONES, 1'b0);
      run_transfers(160);
      reconfigure(16'd0, 8'd255, 1'b1, ALL_ONES, 1'b1);
      run_transfers(160);
      reconfigure(BLKSIZE_MAX, 8'd1, 1'b1, 64'd0, 1'b0);
      run_transfers(160);
      reconfigure(16'd1, 8'd128, 1'b1, 64'd65536, 1'b1);
      run_transfers(160);
      reconfigure(BLKSIZE_MIN, 8'd0, 1'b0, 64'd0, 1'b1);
      run_transfers(160);
      reconfigure(16'($urandom_range(0, BLKSIZE_MAX)), 8'($urandom),
                  1'($urandom_range(0, 1)), {$urandom, $urandom}, 1'($urandom_range(0, 1)));
      run_transfers(160);
      reconfigure(BLKSIZE_MAX, 8'd255, 1'b1, ALL_ONES, 1'b1);
      run_transfers(160);

      hold_until_drained();
      $display("Covered %0d requests (%0d directed) over %0d register settings.",
               sent, directed, settings);
      $display("Responses: %0d ack, %0d option ack, %0d error, %0d silent; %0d mismatches.",
               sb.kind_count[SEND_ACK], sb.kind_count[SEND_OACK],
               sb.kind_count[SEND_ERROR], sb.kind_count[SEND_NONE], sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("[tftp_write_receiver_unit] OK");
      end else begin
         $display("[tftp_write_receiver_unit] ERROR");
      end
      $finish;
   end

endmodule
